[rtl/core/prp_pkg.sv]
// ---------------------------------------------------------------------------
// prp_pkg: shared definitions for the partial random permutation block
// Sizes, status and op codes, microcode step addresses, the control word
// layout and the microcode program ROM.
// ---------------------------------------------------------------------------
package prp_pkg;

   // Pool and field sizes
   localparam int POOL_MAX  = 1024;
   localparam int ADDR_W    = $clog2(POOL_MAX);
   localparam int FIELD_W   = 11;
   localparam int FRAC_BITS = 32;
   localparam int PROD_W    = FIELD_W + FRAC_BITS;

   // Store entry: candidate value in the low bits, epoch tag above it
   localparam int EPOCH_W   = 8;
   localparam int RAM_W     = FIELD_W + EPOCH_W;

   // Stream payload widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 16;

   // Input op codes (req_tuser)
   localparam logic OP_START = 1'b0;
   localparam logic OP_DRAW  = 1'b1;

   // Result status codes (rsp_tuser)
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_BAD_START = 2'd1;
   localparam logic [1:0] STAT_EMPTY     = 2'd2;

   // Microcode step addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_DECODE  = 4'd1;
   localparam logic [STEP_W-1:0] STEP_CHECK   = 4'd2;
   localparam logic [STEP_W-1:0] STEP_MUL     = 4'd3;
   localparam logic [STEP_W-1:0] STEP_RD_SEL  = 4'd4;
   localparam logic [STEP_W-1:0] STEP_RD_TAIL = 4'd5;
   localparam logic [STEP_W-1:0] STEP_DRAW    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_START   = 4'd7;
   localparam logic [STEP_W-1:0] STEP_CLEAR   = 4'd8;
   localparam logic [STEP_W-1:0] STEP_EPOCH   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_EMPTY   = 4'd10;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEXT,
      COND_ALWAYS,
      COND_NO_ITEM,
      COND_START,
      COND_EMPTY,
      COND_ZERO,
      COND_NO_WRAP,
      COND_CLR_MORE
   } cond_type;

   // Result kinds a step can emit
   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_START,
      EMIT_DRAW,
      EMIT_EMPTY
   } emit_type;

   typedef struct packed {
      logic                ready;
      logic                ld_prod;
      logic                rd_sel;
      logic                rd_tail;
      logic                ld_value;
      logic                clr_wr;
      logic                epoch_one;
      emit_type            emit;
      cond_type            cond;
      logic [STEP_W-1:0]   target;
   } ctrl_word_type;

   // Microcode program: one control word per step
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw        = '0;
      cw.emit   = EMIT_NONE;
      cw.cond   = COND_NEXT;
      cw.target = STEP_FETCH;
      case (step)
         STEP_FETCH: begin
            cw.ready  = 1'b1;
            cw.cond   = COND_NO_ITEM;
            cw.target = STEP_FETCH;
         end
         STEP_DECODE: begin
            cw.cond   = COND_START;
            cw.target = STEP_START;
         end
         STEP_CHECK: begin
            cw.cond   = COND_EMPTY;
            cw.target = STEP_EMPTY;
         end
         STEP_MUL: begin
            cw.ld_prod = 1'b1;
            cw.cond    = COND_ZERO;
            cw.target  = STEP_FETCH;
         end
         STEP_RD_SEL: begin
            cw.rd_sel = 1'b1;
         end
         STEP_RD_TAIL: begin
            cw.rd_tail  = 1'b1;
            cw.ld_value = 1'b1;
         end
         STEP_DRAW: begin
            cw.emit   = EMIT_DRAW;
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_FETCH;
         end
         STEP_START: begin
            cw.emit   = EMIT_START;
            cw.cond   = COND_NO_WRAP;
            cw.target = STEP_FETCH;
         end
         STEP_CLEAR: begin
            cw.clr_wr = 1'b1;
            cw.cond   = COND_CLR_MORE;
            cw.target = STEP_CLEAR;
         end
         STEP_EPOCH: begin
            cw.epoch_one = 1'b1;
            cw.cond      = COND_ALWAYS;
            cw.target    = STEP_FETCH;
         end
         STEP_EMPTY: begin
            cw.emit   = EMIT_EMPTY;
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_FETCH;
         end
         default: begin
            cw.cond   = COND_ALWAYS;
            cw.target = STEP_FETCH;
         end
      endcase
      return cw;
   endfunction

endpackage

[rtl/core/partial_random_permutation.sv]
// ---------------------------------------------------------------------------
// partial_random_permutation: draws distinct values 1..n without replacement
// Partial Fisher-Yates shuffle run by a small microcoded sequencer over a
// single-port-read candidate RAM.
// ---------------------------------------------------------------------------
// Usage:
//  - req channel: one transfer per item. req_tuser selects the op: start
//    (pool size n and pick count k in req_tdata) or draw (32-bit random
//    fraction in req_tdata). A draw with a zero fraction while picks are
//    left gives no result; every other item gives exactly one rsp transfer.
//  - rsp channel: picked value in rsp_tdata, final pick flag on rsp_tlast,
//    status on rsp_tuser (ok, start rejected, no picks left).
//  - Timing: a draw's result is registered after the steps decode, check,
//    multiply, read the picked slot, read the tail slot, and write back and
//    emit; a start's after decode and emit, a draw with no picks left after
//    decode, check and emit. A new item is taken only back at fetch, so
//    one item is done before the next is taken. The cost is set by the
//    one read port of the candidate RAM and the registered multiplier.
//  - Each start bumps an epoch tag that marks store entries as written. When
//    the tag wraps (every 255 starts) and after reset the sequencer sweeps
//    the RAM, one entry a cycle, all 1024 entries, then reloads the tag;
//    during this req_tready stays low.
//  - A stalled receiver holds the result in the output register; the
//    sequencer waits at its emit step until the register frees up.
// ---------------------------------------------------------------------------
module partial_random_permutation (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [10:0] pool_size, [21:11] pick_count, [53:22] random_fraction, [55:54] 0
   input  logic [prp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [0] op
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [10:0] picked_value, [15:11] 0
   output logic [prp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // last_pick
   output logic                            rsp_tlast,
   // [1:0] status
   output logic [1:0]                      rsp_tuser
);

   localparam logic [prp_pkg::EPOCH_W-1:0] EPOCH_MAX = {prp_pkg::EPOCH_W{1'b1}};
   localparam logic [prp_pkg::ADDR_W-1:0]  ADDR_LAST = {prp_pkg::ADDR_W{1'b1}};

   // Sequencer
   logic [prp_pkg::STEP_W-1:0] pc_ff, pc_in;
   prp_pkg::ctrl_word_type     cw;
   logic                       cond_true;
   logic                       out_busy;
   logic                       stall;
   logic                       go;
   logic                       req_accept;

   // Captured item
   logic                         op_ff, op_in;
   logic [prp_pkg::FIELD_W-1:0]  pool_ff, pool_in;
   logic [prp_pkg::FIELD_W-1:0]  pick_ff, pick_in;
   logic [prp_pkg::FRAC_BITS-1:0] frac_ff, frac_in;

   // Draw state
   logic [prp_pkg::FIELD_W-1:0]  rem_ff, rem_in;
   logic [prp_pkg::FIELD_W-1:0]  picks_ff, picks_in;
   logic [prp_pkg::EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [prp_pkg::ADDR_W-1:0]   clr_ff, clr_in;
   logic [prp_pkg::FIELD_W-1:0]  prod_hi_ff, prod_hi_in;
   logic [prp_pkg::FIELD_W-1:0]  value_ff, value_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [prp_pkg::FIELD_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [1:0]                   rsp_status_ff, rsp_status_in;

   // Datapath
   logic [prp_pkg::PROD_W-1:0]   prod_full;
   logic [prp_pkg::FIELD_W-1:0]  sel_full;
   logic [prp_pkg::FIELD_W-1:0]  tail_full;
   logic [prp_pkg::ADDR_W-1:0]   sel_addr;
   logic [prp_pkg::ADDR_W-1:0]   tail_addr;
   logic [prp_pkg::FIELD_W-1:0]  tail_value;
   logic                         start_bad;

   // RAM port
   logic                         ram_wr_en;
   logic [prp_pkg::ADDR_W-1:0]   ram_wr_addr;
   logic [prp_pkg::RAM_W-1:0]    ram_wr_data;
   logic                         ram_rd_en;
   logic [prp_pkg::ADDR_W-1:0]   ram_rd_addr;
   logic [prp_pkg::RAM_W-1:0]    ram_rd_data;

   // An entry not written since the last start reads as its index plus one
   function automatic logic [prp_pkg::FIELD_W-1:0] resolve_entry(
      input logic [prp_pkg::RAM_W-1:0]   word,
      input logic [prp_pkg::EPOCH_W-1:0] epoch,
      input logic [prp_pkg::ADDR_W-1:0]  addr
   );
      logic [prp_pkg::FIELD_W-1:0] ident;
      ident = prp_pkg::FIELD_W'(addr) + prp_pkg::FIELD_W'(1);
      if (word[prp_pkg::RAM_W-1:prp_pkg::FIELD_W] == epoch) begin
         return word[prp_pkg::FIELD_W-1:0];
      end
      return ident;
   endfunction

   prp_ram #(
      .WIDTH (prp_pkg::RAM_W),
      .DEPTH (prp_pkg::POOL_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Fetch the control word for the current step
   assign cw         = prp_pkg::ucode_rom(pc_ff);
   assign req_tready = cw.ready;
   assign req_accept = req_tvalid && req_tready;

   // Hold at an emit step while the output register is full
   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign stall    = (cw.emit != prp_pkg::EMIT_NONE) && out_busy;
   assign go       = !stall;

   // Index = (remaining * u) >> 32, clamped into the live part
   assign prod_full = prp_pkg::PROD_W'(rem_ff) * prp_pkg::PROD_W'(frac_ff);
   assign tail_full = rem_ff - prp_pkg::FIELD_W'(1);
   assign sel_full  = (prod_hi_ff >= rem_ff) ? tail_full : prod_hi_ff;
   assign sel_addr  = sel_full[prp_pkg::ADDR_W-1:0];
   assign tail_addr = tail_full[prp_pkg::ADDR_W-1:0];
   assign tail_value = resolve_entry(ram_rd_data, epoch_ff, tail_addr);

   assign start_bad = (pick_ff > pool_ff) ||
                      (pool_ff > prp_pkg::FIELD_W'(prp_pkg::POOL_MAX));

   // RAM: the sweep writes a stale tag; a draw moves the tail into the slot
   assign ram_wr_en   = go && (cw.clr_wr || (cw.emit == prp_pkg::EMIT_DRAW));
   assign ram_wr_addr = cw.clr_wr ? clr_ff : sel_addr;
   assign ram_wr_data = cw.clr_wr ? '0 : {epoch_ff, tail_value};
   assign ram_rd_en   = cw.rd_sel || cw.rd_tail;
   assign ram_rd_addr = cw.rd_sel ? sel_addr : tail_addr;

   // Jump condition
   always_comb begin
      case (cw.cond)
         prp_pkg::COND_NEXT:     cond_true = 1'b0;
         prp_pkg::COND_ALWAYS:   cond_true = 1'b1;
         prp_pkg::COND_NO_ITEM:  cond_true = !req_accept;
         prp_pkg::COND_START:    cond_true = (op_ff == prp_pkg::OP_START);
         prp_pkg::COND_EMPTY:    cond_true = (picks_ff == '0) || (rem_ff == '0);
         prp_pkg::COND_ZERO:     cond_true = (frac_ff == '0);
         prp_pkg::COND_NO_WRAP:  cond_true = (epoch_ff != EPOCH_MAX);
         prp_pkg::COND_CLR_MORE: cond_true = (clr_ff != ADDR_LAST);
         default:                cond_true = 1'b1;
      endcase
   end

   always_comb begin
      pc_in         = pc_ff;
      op_in         = op_ff;
      pool_in       = pool_ff;
      pick_in       = pick_ff;
      frac_in       = frac_ff;
      rem_in        = rem_ff;
      picks_in      = picks_ff;
      epoch_in      = epoch_ff;
      clr_in        = clr_ff;
      prod_hi_in    = prod_hi_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // Capture the item on its transfer
      if (req_accept) begin
         op_in   = req_tuser;
         pool_in = req_tdata[10:0];
         pick_in = req_tdata[21:11];
         frac_in = req_tdata[53:22];
      end

      if (go) begin
         pc_in = cond_true ? cw.target : pc_ff + prp_pkg::STEP_W'(1);

         if (cw.ld_prod) begin
            prod_hi_in = prod_full[prp_pkg::PROD_W-1:prp_pkg::FRAC_BITS];
         end
         if (cw.ld_value) begin
            value_in = resolve_entry(ram_rd_data, epoch_ff, sel_addr);
         end
         if (cw.clr_wr) begin
            clr_in = clr_ff + prp_pkg::ADDR_W'(1);
         end
         if (cw.epoch_one) begin
            epoch_in = prp_pkg::EPOCH_W'(1);
         end

         case (cw.emit)
            prp_pkg::EMIT_START: begin
               rem_in        = start_bad ? '0 : pool_ff;
               picks_in      = start_bad ? '0 : pick_ff;
               // A wrapped tag goes through the sweep instead
               if (epoch_ff != EPOCH_MAX) begin
                  epoch_in = epoch_ff + prp_pkg::EPOCH_W'(1);
               end
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = start_bad ? prp_pkg::STAT_BAD_START : prp_pkg::STAT_OK;
            end
            prp_pkg::EMIT_DRAW: begin
               rem_in        = rem_ff - prp_pkg::FIELD_W'(1);
               picks_in      = picks_ff - prp_pkg::FIELD_W'(1);
               rsp_valid_in  = 1'b1;
               rsp_value_in  = value_ff;
               rsp_last_in   = (picks_ff == prp_pkg::FIELD_W'(1));
               rsp_status_in = prp_pkg::STAT_OK;
            end
            prp_pkg::EMIT_EMPTY: begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b0;
               rsp_status_in = prp_pkg::STAT_EMPTY;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= prp_pkg::STEP_CLEAR;
         clr_ff       <= '0;
         epoch_ff     <= prp_pkg::EPOCH_W'(1);
         rem_ff       <= '0;
         picks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         clr_ff       <= clr_in;
         epoch_ff     <= epoch_in;
         rem_ff       <= rem_in;
         picks_ff     <= picks_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      pool_ff       <= pool_in;
      pick_ff       <= pick_in;
      frac_ff       <= frac_in;
      prod_hi_ff    <= prod_hi_in;
      value_ff      <= value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = prp_pkg::RSP_DATA_W'(rsp_value_ff);
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // Picks left never exceed the live part of the store
   assert property (@(posedge clock) disable iff (reset)
      picks_ff <= rem_ff)
      else $error("picks left exceed remaining candidates");

   // A step stalled on a full output register keeps its place
   assert property (@(posedge clock) disable iff (reset)
      stall |=> $stable(pc_ff))
      else $error("sequencer advanced while output register was full");

   // Each emitted draw shrinks the live part by exactly one
   assert property (@(posedge clock) disable iff (reset)
      (go && (cw.emit == prp_pkg::EMIT_DRAW)) |=>
         (rem_ff == $past(rem_ff) - prp_pkg::FIELD_W'(1)))
      else $error("draw did not shrink the live part by one");

endmodule

[rtl/core/prp_ram.sv]
// ---------------------------------------------------------------------------
// prp_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered and holds
// until the next read.
// ---------------------------------------------------------------------------
module prp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
